// ----- design/lkv_pkg.sv -----
// Package for the LRU key-value cache.
// Holds the controller state type, command codes and the control struct.
// No dependencies.
`default_nettype none

package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkv_state_e;

  typedef struct packed {
    logic capture;
    logic update;
  } lkv_ctrl_t;

endpackage

`default_nettype wire

// ----- design/lru_key_value_cache.sv -----
// An item is accepted while the block is idle; its command, key, data and key
// matches are registered in the capture/compare step. The shift/update step then
// writes the entry registers and registers the result, waiting while a held result
// blocks the output. A new item is accepted only after the update step is done.
// Reset clears the entry count (store empty), sets capacity to 16 and leaves
// the block ready at once; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    cmd_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] data_in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         hit_o,
  output logic signed [VAL_W-1:0]      data_out_o,
  output logic                         evicted_o
);

  lkv_ctrl_t ctrl;

  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  lkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .hit_o       (hit_o),
    .data_out_o  (data_out_o),
    .evicted_o   (evicted_o)
  );

endmodule

`default_nettype wire

// ----- design/lkv_ctrl.sv -----
// Controller state machine of the LRU key-value cache.
// Sequences capture and update of an item and owns the output valid flag.
// Depends on lkv_pkg.
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output lkv_ctrl_t  ctrl_o
);

  lkv_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.capture = 1'b0;
    ctrl_o.update  = 1'b0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        ctrl_o.capture = in_valid_i;
      end
      ST_UPDATE: begin
        ctrl_o.update = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.update) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/lkv_dp.sv -----
// Datapath of the LRU key-value cache: entries in recency order, parallel
// key compare, move-to-front and insert shifting, and the result register.
// Depends on lkv_pkg.
`default_nettype none

module lkv_dp
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lkv_ctrl_t           ctrl_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                cmd_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] data_in_i,
  output logic                     hit_o,
  output logic signed [VAL_W-1:0]  data_out_o,
  output logic                     evicted_o
);

  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int IdxW = $clog2(ENTRIES);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;
  localparam logic [CmpW-1:0] EntriesCmp = CmpW'(ENTRIES);

  logic [KEY_W-1:0] keys_q [ENTRIES];
  logic [KEY_W-1:0] keys_d [ENTRIES];
  logic [VAL_W-1:0] vals_q [ENTRIES];
  logic [VAL_W-1:0] vals_d [ENTRIES];
  logic [CntW-1:0]  count_q, count_d;
  logic [CAP_W-1:0] cap_q;

  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] data_q;
  logic [ENTRIES-1:0] match_q, match_d;

  logic             hit;
  logic [IdxW-1:0]  pos;
  logic [VAL_W-1:0] hit_val;
  logic [CmpW-1:0]  cap_ext;
  logic [CntW-1:0]  eff_cap;
  logic             full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = (CntW'(i) < count_q) && (keys_q[i] == key_i);
    end
  end

  always_comb begin
    pos     = '0;
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pos     = pos | (match_q[i] ? IdxW'(i) : '0);
      hit_val = hit_val | (match_q[i] ? vals_q[i] : '0);
    end
  end

  assign hit     = |match_q;
  assign cap_ext = CmpW'(cap_q);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CntW'(1);
    end else if (cap_ext > EntriesCmp) begin
      eff_cap = CntW'(ENTRIES);
    end else begin
      eff_cap = CntW'(cap_ext);
    end
  end

  assign full = count_q >= eff_cap;

  always_comb begin
    keys_d  = keys_q;
    vals_d  = vals_q;
    count_d = count_q;
    if (hit) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (IdxW'(i) <= pos) begin
          keys_d[i] = keys_q[i-1];
          vals_d[i] = vals_q[i-1];
        end
      end
      keys_d[0] = key_q;
      vals_d[0] = (cmd_q == CMD_SET) ? data_q : hit_val;
    end else if (cmd_q == CMD_SET) begin
      for (int i = 1; i < ENTRIES; i++) begin
        keys_d[i] = keys_q[i-1];
        vals_d[i] = vals_q[i-1];
      end
      keys_d[0] = key_q;
      vals_d[0] = data_q;
      count_d   = full ? eff_cap : count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (ctrl_i.update) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      data_q  <= data_in_i;
      match_q <= match_d;
    end
    if (ctrl_i.update) begin
      keys_q     <= keys_d;
      vals_q     <= vals_d;
      hit_o      <= hit;
      data_out_o <= (hit && cmd_q == CMD_GET) ? hit_val : '0;
      evicted_o  <= !hit && cmd_q == CMD_SET && full;
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_lru_key_value_cache.sv -----
// Self-checking testbench for lru_key_value_cache: get and set items against an LRU predictor.
// Covers capacity settings, sender and receiver idling, and a long receiver hold-off.
// Depends on lkv_pkg and the lru_key_value_cache module.
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int ENTRIES = 16;
  localparam int POOL_SIZE = 20;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
    logic             evicted;
  } cache_reply_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CAP_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    cmd_i;
  logic signed [KEY_W-1:0] key_i;
  logic signed [VAL_W-1:0] data_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    hit_o;
  logic signed [VAL_W-1:0] data_out_o;
  logic                    evicted_o;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o      (hit_o),
    .data_out_o (data_out_o),
    .evicted_o  (evicted_o)
  );

  logic [KEY_W-1:0] lru_keys [ENTRIES];
  logic [VAL_W-1:0] lru_vals [ENTRIES];
  int               lru_count = 0;
  logic [CAP_W-1:0] lru_capacity = CAP_RESET;
  cache_reply_t     expected_replies [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int replies_checked = 0;
  int hit_total = 0;
  int evict_total = 0;
  int error_count = 0;

  wire in_accept = in_valid_i && !in_stall_o;
  wire out_accept = out_valid_o && !out_stall_i;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic cache_reply_t apply_request(input logic cmd, input logic [KEY_W-1:0] key,
                                                 input logic [VAL_W-1:0] val);
    cache_reply_t     r;
    int               pos;
    int               cap_now;
    int               new_count;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    r = '0;
    pos = -1;
    for (int i = 0; i < lru_count; i++) begin
      if (pos < 0 && lru_keys[i] == key) pos = i;
    end
    if (pos >= 0) begin
      r.hit = 1'b1;
      k = lru_keys[pos];
      v = lru_vals[pos];
      for (int i = pos; i > 0; i--) begin
        lru_keys[i] = lru_keys[i-1];
        lru_vals[i] = lru_vals[i-1];
      end
      lru_keys[0] = k;
      lru_vals[0] = (cmd == CMD_SET) ? val : v;
      if (cmd == CMD_GET) r.data = v;
    end else if (cmd == CMD_SET) begin
      cap_now = (lru_capacity == 0) ? 1 : (lru_capacity > ENTRIES) ? ENTRIES : lru_capacity;
      if (lru_count >= cap_now) begin
        new_count = cap_now;
        r.evicted = 1'b1;
      end else begin
        new_count = lru_count + 1;
      end
      for (int i = new_count - 1; i > 0; i--) begin
        lru_keys[i] = lru_keys[i-1];
        lru_vals[i] = lru_vals[i-1];
      end
      lru_keys[0] = key;
      lru_vals[0] = val;
      lru_count = new_count;
    end
    hit_total += int'(r.hit);
    evict_total += int'(r.evicted);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= key;
    data_in_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_replies.push_back(apply_request(cmd, key, val));
    requests_sent++;
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lru_capacity = value;
  endtask

  task automatic send_random_request();
    logic [KEY_W-1:0] key;
    key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_request(1'($urandom_range(0, 1)), key, $urandom);
  endtask

  task automatic test_empty_and_extremes();
    // Key zero must miss on an empty store, whatever the unused slots hold.
    send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    send_request(CMD_SET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  task automatic test_lowered_capacity();
    // Entries beyond a lowered capacity still hit until the next insert trims them.
    write_capacity(5'd2);
    send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_SET, 32'h5555_AAAA, 32'hCAFE_0001);
    send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
  endtask

  task automatic test_capacity_zero();
    // A capacity of zero behaves as a capacity of one.
    write_capacity(5'd0);
    send_request(CMD_SET, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
    send_request(CMD_SET, 32'h5A5A_A5A5, 32'hF0F0_0F0F);
    send_request(CMD_GET, 32'hA5A5_5A5A, 32'h0000_0000);
    send_request(CMD_GET, 32'h5A5A_A5A5, 32'h0000_0000);
  endtask

  task automatic test_random(input int count, input logic [CAP_W-1:0] cap);
    write_capacity(cap);
    repeat (count) send_random_request();
  endtask

  task automatic test_backpressure();
    settle_idle();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    repeat (24) send_random_request();
  endtask

  always @(posedge clk_i) begin : check_replies
    cache_reply_t want;
    if (rst_ni && out_accept) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual hit=%0b data=%0h evicted=%0b",
                 $time, hit_o, data_out_o, evicted_o);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("hit", VAL_W'(want.hit), VAL_W'(hit_o));
        compare_field("data_out", want.data, data_out_o);
        compare_field("evicted", VAL_W'(want.evicted), VAL_W'(evicted_o));
        replies_checked++;
      end
    end
  end

  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (in_accept || out_accept) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_GET;
    key_i <= '0;
    data_in_i <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 13;
    recv_stall_pct = 82;
    test_empty_and_extremes();
    test_lowered_capacity();
    test_capacity_zero();
    test_random(250, 5'd31);
    test_random(250, 5'd16);
    send_gap_pct = 82;
    recv_stall_pct = 13;
    test_random(250, 5'd3);
    test_random(250, 5'd0);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(250, 5'd1);
    test_random(230, CAP_W'($urandom_range(2, 15)));
    test_backpressure();
    settle_idle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results: %0d hits, %0d evictions.",
             requests_sent, replies_checked, hit_total, evict_total);
    $display("Capacities 0 to 31 with idling on both sides and a long output hold-off.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lkv_pkg.sv
design/lkv_ctrl.sv
design/lkv_dp.sv
design/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
